>>> hw/rtl/ssa_pkg.sv
// Shared types, codes and constants of the sample slot allocator.
`timescale 1ns / 1ps
package ssa_pkg;

  localparam int MAX_SLOTS_DEF  = 64;
  localparam int NUM_VOICES_DEF = 24;

  localparam int ADDR_W   = 19;
  localparam int BYTES_W  = 20;
  localparam int RATE_W   = 18;
  localparam int ID_W     = 8;
  localparam int PITCH_W  = 15;
  localparam int VADDR_W  = 16;
  localparam int VOICE_W  = 6;
  localparam int USED_W   = 9;
  localparam int SLOT_W   = ADDR_W + RATE_W;
  localparam int CFG_IDX_W = 1;

  localparam logic [BYTES_W-1:0] BASE_RESET  = 20'h01010;
  localparam logic [BYTES_W-1:0] RAM_RESET   = 20'h80000;
  localparam logic [BYTES_W-1:0] ADDR_SPACE  = 20'h80000;
  localparam logic [PITCH_W-1:0] PITCH_MAX   = 15'd16384;

  // floor(rate * 4096 / 44100) == (rate * PITCH_RECIP) >> PITCH_SHIFT for 18-bit rates
  localparam int PITCH_SHIFT = 34;
  localparam logic [63:0] PITCH_RECIP_64 = ((64'd1 << 46) + 64'd44099) / 64'd44100;
  localparam logic [30:0] PITCH_RECIP = PITCH_RECIP_64[30:0];
  localparam int PROD_W = RATE_W + 31;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_FULL     = 2'd1,
    ST_BAD_SLOT = 2'd2,
    ST_NO_RAM   = 2'd3
  } status_e;

  typedef enum logic {
    OP_ADD  = 1'b0,
    OP_PLAY = 1'b1
  } op_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ALLOC_BASE = 1'b0,
    CFG_RAM_BYTES  = 1'b1
  } cfg_idx_e;

  typedef struct packed {
    logic latch;
    logic add;
    logic reject;
    logic read;
    logic mul;
    logic play;
  } cmd_t;

  typedef struct packed {
    logic is_play;
    logic play_ok;
    logic out_free;
  } sts_t;

endpackage

>>> hw/rtl/ssa_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module ssa_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> hw/rtl/ssa_ctrl.sv
// Sequencer for add and play requests.
`timescale 1ns / 1ps
module ssa_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_stall_o,
  input  ssa_pkg::sts_t sts_i,
  output ssa_pkg::cmd_t cmd_o
);
  import ssa_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_EXEC = 4'b0010,
    S_READ = 4'b0100,
    S_MUL  = 4'b1000
  } state_e;

  state_e state_q, state_d;

  assign in_stall_o = (state_q != S_IDLE);

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.latch = 1'b1;
          state_d     = S_EXEC;
        end
      end
      S_EXEC: begin
        if (!sts_i.is_play) begin
          if (sts_i.out_free) begin
            cmd_o.add = 1'b1;
            state_d   = S_IDLE;
          end
        end else if (!sts_i.play_ok) begin
          if (sts_i.out_free) begin
            cmd_o.reject = 1'b1;
            state_d      = S_IDLE;
          end
        end else begin
          cmd_o.read = 1'b1;
          state_d    = S_READ;
        end
      end
      S_READ: begin
        cmd_o.mul = 1'b1;
        state_d   = S_MUL;
      end
      S_MUL: begin
        if (sts_i.out_free) begin
          cmd_o.play = 1'b1;
          state_d    = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  a_accept_to_exec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> (state_q == S_EXEC))
    else $error("accepted request did not enter execution");

  a_read_then_mul: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.read |=> (cmd_o.mul && $past(sts_i.play_ok)))
    else $error("table read not followed by pitch multiply");

  a_state_onehot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot(state_q))
    else $error("state register not one-hot");

endmodule

>>> hw/rtl/ssa_dp.sv
// Slot table, pointers, pitch scaling and result register.
`timescale 1ns / 1ps
module ssa_dp #(
  parameter int MAX_SLOTS  = ssa_pkg::MAX_SLOTS_DEF,
  parameter int NUM_VOICES = ssa_pkg::NUM_VOICES_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  ssa_pkg::cmd_t                   cmd_i,
  output ssa_pkg::sts_t                   sts_o,
  input  logic                            cfg_we_i,
  input  logic [ssa_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [ssa_pkg::BYTES_W-1:0]     cfg_data_i,
  input  logic                            operation_i,
  input  logic [ssa_pkg::BYTES_W-1:0]     sample_bytes_i,
  input  logic [ssa_pkg::RATE_W-1:0]      sample_rate_hz_i,
  input  logic [ssa_pkg::ID_W-1:0]        slot_id_i,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output logic [1:0]                      status_o,
  output logic [7:0]                      new_slot_o,
  output logic [ssa_pkg::ADDR_W-1:0]      load_addr_o,
  output logic [ssa_pkg::BYTES_W-1:0]     load_bytes_o,
  output logic [ssa_pkg::VOICE_W-1:0]     voice_o,
  output logic [ssa_pkg::PITCH_W-1:0]     pitch_o,
  output logic [ssa_pkg::VADDR_W-1:0]     voice_addr_o,
  output logic [ssa_pkg::USED_W-1:0]      slots_used_o
);
  import ssa_pkg::*;

  localparam int CNT_W = $clog2(MAX_SLOTS + 1);
  localparam int IDX_W = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
  localparam int VP_W  = (NUM_VOICES > 1) ? $clog2(NUM_VOICES) : 1;

  // latched request
  logic                op_q;
  logic [BYTES_W-1:0]  size_q;
  logic [RATE_W-1:0]   rate_q;
  logic [ID_W-1:0]     id_q;

  // allocator state and configuration
  logic [CNT_W-1:0]    cnt_q, cnt_d;
  logic [BYTES_W-1:0]  fp_q, fp_d;
  logic [VP_W-1:0]     vp_q, vp_d;
  logic [ADDR_W-1:0]   base_q, base_d;
  logic [BYTES_W-1:0]  rbytes_q, rbytes_d;

  // result register
  logic                out_valid_q;
  logic [1:0]          status_q, status_d;
  logic [7:0]          new_slot_q, new_slot_d;
  logic [ADDR_W-1:0]   load_addr_q, load_addr_d;
  logic [BYTES_W-1:0]  load_bytes_q, load_bytes_d;
  logic [VOICE_W-1:0]  voice_q, voice_d;
  logic [PITCH_W-1:0]  pitch_q, pitch_d;
  logic [VADDR_W-1:0]  vaddr_q, vaddr_d;
  logic [USED_W-1:0]   used_q, used_d;

  logic [PITCH_W-1:0]  prod_q;

  logic [20:0]         padded;
  logic [21:0]         end_addr;
  logic [BYTES_W-1:0]  limit;
  logic                full, no_ram;
  logic [SLOT_W-1:0]   rd_word;
  logic [RATE_W-1:0]   rd_rate;
  logic [ADDR_W-1:0]   rd_addr;
  logic [PROD_W-1:0]   prod;
  logic                add_ok;

  assign padded   = (21'(size_q) + 21'd63) & ~21'd63;
  assign end_addr = 22'(fp_q) + 22'(padded);
  assign limit    = (rbytes_q > ADDR_SPACE) ? ADDR_SPACE : rbytes_q;
  assign full     = (cnt_q >= CNT_W'(MAX_SLOTS));
  assign no_ram   = (fp_q >= limit) || (end_addr > 22'(limit));
  assign add_ok   = cmd_i.add && !full && !no_ram;

  assign sts_o.is_play  = (op_q == OP_PLAY);
  assign sts_o.play_ok  = (USED_W'(id_q) < USED_W'(cnt_q));
  assign sts_o.out_free = !out_valid_q || !out_stall_i;

  ssa_ram #(
    .WIDTH (SLOT_W),
    .DEPTH (MAX_SLOTS)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (add_ok),
    .waddr_i (IDX_W'(cnt_q)),
    .wdata_i ({rate_q, fp_q[ADDR_W-1:0]}),
    .re_i    (cmd_i.read),
    .raddr_i (IDX_W'(id_q)),
    .rdata_o (rd_word)
  );

  assign rd_rate = rd_word[SLOT_W-1:ADDR_W];
  assign rd_addr = rd_word[ADDR_W-1:0];
  assign prod    = PROD_W'(rd_rate) * PROD_W'(PITCH_RECIP);

  always_comb begin
    cnt_d    = cnt_q;
    fp_d     = fp_q;
    vp_d     = vp_q;
    base_d   = base_q;
    rbytes_d = rbytes_q;
    if (add_ok) begin
      cnt_d = cnt_q + CNT_W'(1);
      fp_d  = end_addr[BYTES_W-1:0];
    end
    if (cmd_i.play) begin
      vp_d = (vp_q == VP_W'(NUM_VOICES - 1)) ? '0 : vp_q + VP_W'(1);
    end
    if (cfg_we_i) begin
      unique case (cfg_index_i)
        CFG_ALLOC_BASE: begin
          base_d = cfg_data_i[ADDR_W-1:0];
          if (cnt_q == '0) begin
            fp_d = BYTES_W'(cfg_data_i[ADDR_W-1:0]);
          end
        end
        CFG_RAM_BYTES: rbytes_d = cfg_data_i;
        default: ;
      endcase
    end
  end

  always_comb begin
    status_d     = ST_OK;
    new_slot_d   = '0;
    load_addr_d  = '0;
    load_bytes_d = '0;
    voice_d      = '0;
    pitch_d      = '0;
    vaddr_d      = '0;
    used_d       = USED_W'(cnt_q);
    if (cmd_i.add) begin
      if (full) begin
        status_d = ST_FULL;
      end else if (no_ram) begin
        status_d = ST_NO_RAM;
      end else begin
        new_slot_d   = 8'(cnt_q);
        load_addr_d  = fp_q[ADDR_W-1:0];
        load_bytes_d = padded[BYTES_W-1:0];
        used_d       = USED_W'(cnt_q) + USED_W'(1);
      end
    end else if (cmd_i.reject) begin
      status_d = ST_BAD_SLOT;
    end else begin
      voice_d = VOICE_W'(vp_q);
      pitch_d = (prod_q > PITCH_MAX) ? PITCH_MAX : prod_q;
      vaddr_d = rd_addr[ADDR_W-1:3];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q       <= '0;
      fp_q        <= BASE_RESET;
      vp_q        <= '0;
      base_q      <= BASE_RESET[ADDR_W-1:0];
      rbytes_q    <= RAM_RESET;
      out_valid_q <= 1'b0;
    end else begin
      cnt_q    <= cnt_d;
      fp_q     <= fp_d;
      vp_q     <= vp_d;
      base_q   <= base_d;
      rbytes_q <= rbytes_d;
      if (cmd_i.add || cmd_i.reject || cmd_i.play) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.latch) begin
      op_q   <= operation_i;
      size_q <= sample_bytes_i;
      rate_q <= sample_rate_hz_i;
      id_q   <= slot_id_i;
    end
    if (cmd_i.mul) begin
      prod_q <= prod[PITCH_SHIFT +: PITCH_W];
    end
    if (cmd_i.add || cmd_i.reject || cmd_i.play) begin
      status_q     <= status_d;
      new_slot_q   <= new_slot_d;
      load_addr_q  <= load_addr_d;
      load_bytes_q <= load_bytes_d;
      voice_q      <= voice_d;
      pitch_q      <= pitch_d;
      vaddr_q      <= vaddr_d;
      used_q       <= used_d;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign status_o     = status_q;
  assign new_slot_o   = new_slot_q;
  assign load_addr_o  = load_addr_q;
  assign load_bytes_o = load_bytes_q;
  assign voice_o      = voice_q;
  assign pitch_o      = pitch_q;
  assign voice_addr_o = vaddr_q;
  assign slots_used_o = used_q;

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CNT_W'(MAX_SLOTS))
    else $error("slot count above table depth");

  a_voice_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    6'(vp_q) < 6'(NUM_VOICES))
    else $error("voice pointer out of range");

  a_reject_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.add && (full || no_ram) && !cfg_we_i) |=> ($stable(cnt_q) && $stable(fp_q)))
    else $error("rejected add changed allocator state");

endmodule

>>> hw/rtl/sample_slot_allocator_voice_rr_unit.sv
// Top level of the sample slot allocator with round-robin voice assignment.
// One request in flight. Add, rejected play: the request is latched on accept and its
// result registered from execute. Valid play first passes the registered table read
// and the registered pitch multiply. A stalled result holds off the next result.
// Async active-low reset clears slot count and voice pointer, sets base to 0x1010 and
// the free pointer to the base; table contents stay undefined, no clearing pass.
`timescale 1ns / 1ps
module sample_slot_allocator_voice_rr_unit #(
  parameter int MAX_SLOTS  = ssa_pkg::MAX_SLOTS_DEF,
  parameter int NUM_VOICES = ssa_pkg::NUM_VOICES_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [ssa_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [ssa_pkg::BYTES_W-1:0]   cfg_data_i,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic                          operation_i,
  input  logic [ssa_pkg::BYTES_W-1:0]   sample_bytes_i,
  input  logic [ssa_pkg::RATE_W-1:0]    sample_rate_hz_i,
  input  logic [ssa_pkg::ID_W-1:0]      slot_id_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [1:0]                    status_o,
  output logic [7:0]                    new_slot_o,
  output logic [ssa_pkg::ADDR_W-1:0]    load_addr_o,
  output logic [ssa_pkg::BYTES_W-1:0]   load_bytes_o,
  output logic [ssa_pkg::VOICE_W-1:0]   voice_o,
  output logic [ssa_pkg::PITCH_W-1:0]   pitch_o,
  output logic [ssa_pkg::VADDR_W-1:0]   voice_addr_o,
  output logic [ssa_pkg::USED_W-1:0]    slots_used_o
);
  import ssa_pkg::*;

  cmd_t cmd;
  sts_t sts;

  assign cfg_ready_o = 1'b1;

  ssa_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  ssa_dp #(
    .MAX_SLOTS  (MAX_SLOTS),
    .NUM_VOICES (NUM_VOICES)
  ) u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .sts_o            (sts),
    .cfg_we_i         (cfg_valid_i && cfg_ready_o),
    .cfg_index_i      (cfg_index_i),
    .cfg_data_i       (cfg_data_i),
    .operation_i      (operation_i),
    .sample_bytes_i   (sample_bytes_i),
    .sample_rate_hz_i (sample_rate_hz_i),
    .slot_id_i        (slot_id_i),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .status_o         (status_o),
    .new_slot_o       (new_slot_o),
    .load_addr_o      (load_addr_o),
    .load_bytes_o     (load_bytes_o),
    .voice_o          (voice_o),
    .pitch_o          (pitch_o),
    .voice_addr_o     (voice_addr_o),
    .slots_used_o     (slots_used_o)
  );

endmodule
